### rtl/core/dpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpt_pkg;

  localparam int COORD_WIDTH = 12;
  localparam int DEPTH_W     = 16;
  localparam int POINT_W     = 16;
  localparam int NST         = 9;

  localparam int CFG_AW  = 6;
  localparam int CFG_DW  = 64;
  localparam int IDX_LSB = 3;

  localparam int SCALE_W = 16;
  localparam int DPROD_W = DEPTH_W + SCALE_W;
  localparam int Z_SH    = 14;
  localparam int Z_W     = DPROD_W - Z_SH;
  localparam int PP_W    = 16;
  localparam int FRAC_SH = 4;
  localparam int UQ_W    = COORD_WIDTH + FRAC_SH;
  localparam int DU_W    = ((UQ_W > PP_W) ? UQ_W : PP_W) + 1;
  localparam int PXZ_W   = DU_W + Z_W + 1;
  localparam int LO_W    = 18;
  localparam int IF_W    = 24;
  localparam int XH_W    = PXZ_W - LO_W + IF_W + 1;
  localparam int XL_W    = LO_W + IF_W;
  localparam int PXF_W   = XH_W + LO_W;
  localparam int PXR_W   = PXF_W + 1;
  localparam int PC_SH   = 20;
  localparam int PC_W    = PXR_W - PC_SH;
  localparam int ZC_SH   = 8;
  localparam int PCLO_W  = 20;
  localparam int R_W     = 16;
  localparam int PH_W    = R_W + PC_W - PCLO_W;
  localparam int PL_W    = R_W + PCLO_W + 1;
  localparam int PR_W    = R_W + PC_W;
  localparam int ACC_W   = PR_W + 2;
  localparam int ACC_SH  = 22;
  localparam int RQ_W    = ACC_W + 1 - ACC_SH;
  localparam int TRANS_SH = 6;

  localparam logic signed [RQ_W-1:0] SAT_HI = RQ_W'(32767);
  localparam logic signed [RQ_W-1:0] SAT_LO = -RQ_W'(32768);

  localparam logic signed [23:0] TRANS_Q24 [3] = '{-24'sd1205257, -24'sd587201,
                                                   -24'sd1423069};

  localparam logic [15:0] RST_DEPTH_SCALE     = 16'd13107;
  localparam logic [15:0] RST_MIN_DEPTH       = 16'd51;
  localparam logic [15:0] RST_MAX_DEPTH       = 16'd2560;
  localparam logic [31:0] RST_PRINCIPAL_POINT = 32'd1005789613;
  localparam logic [47:0] RST_INVERSE_FOCAL   = 48'd349536538963;

  typedef enum logic [2:0] {
    REG_DEPTH_SCALE     = 3'd0,
    REG_MIN_DEPTH       = 3'd1,
    REG_MAX_DEPTH       = 3'd2,
    REG_PRINCIPAL_POINT = 3'd3,
    REG_INVERSE_FOCAL   = 3'd4,
    REG_ROT_ROW0        = 3'd5,
    REG_ROT_ROW1        = 3'd6,
    REG_ROT_ROW2        = 3'd7
  } cfg_idx_t;

endpackage

`default_nettype wire

### rtl/core/dpt_pixel_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dpt_pixel_if;
  import dpt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [DEPTH_W-1:0]     depth_sample;
  logic [COORD_WIDTH-1:0] pixel_column;
  logic [COORD_WIDTH-1:0] pixel_row;
  logic                   sample_bad;

  modport source (output valid, depth_sample, pixel_column, pixel_row, sample_bad,
                  input ready);
  modport sink (input valid, depth_sample, pixel_column, pixel_row, sample_bad,
                output ready);
endinterface

`default_nettype wire

### rtl/core/dpt_point_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dpt_point_if;
  import dpt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic signed [POINT_W-1:0] point_z;
  logic                      point_valid;

  modport source (output valid, point_x, point_y, point_z, point_valid, input ready);
  modport sink (input valid, point_x, point_y, point_z, point_valid, output ready);
endinterface

`default_nettype wire

### rtl/core/depth_pixel_to_point_transform.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: nine register stages carry the split multiplications; stage 9 is the output register.
// Throughput: one pixel per cycle unless the output stalls;
// every stage holds its item while the next one is full.
// Reset: synchronous, active low; it empties all stages and loads the register defaults.
module depth_pixel_to_point_transform (
  input  logic                        clk,
  input  logic                        rst_n,
  dpt_pixel_if.sink                   in_pix,
  dpt_point_if.source                 out_pt,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dpt_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [dpt_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [dpt_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import dpt_pkg::*;

  logic [15:0] depth_scale_r, min_depth_r, max_depth_r;
  logic [31:0] principal_point_r;
  logic [47:0] inverse_focal_r;
  logic [47:0] rot_r [3];
  logic        cfg_wr;
  cfg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_idx_t'(cfg_paddr[CFG_AW-1:IDX_LSB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_scale_r     <= RST_DEPTH_SCALE;
      min_depth_r       <= RST_MIN_DEPTH;
      max_depth_r       <= RST_MAX_DEPTH;
      principal_point_r <= RST_PRINCIPAL_POINT;
      inverse_focal_r   <= RST_INVERSE_FOCAL;
      rot_r[0]          <= '0;
      rot_r[1]          <= '0;
      rot_r[2]          <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DEPTH_SCALE:     depth_scale_r     <= cfg_pwdata[15:0];
        REG_MIN_DEPTH:       min_depth_r       <= cfg_pwdata[15:0];
        REG_MAX_DEPTH:       max_depth_r       <= cfg_pwdata[15:0];
        REG_PRINCIPAL_POINT: principal_point_r <= cfg_pwdata[31:0];
        REG_INVERSE_FOCAL:   inverse_focal_r   <= cfg_pwdata[47:0];
        REG_ROT_ROW0:        rot_r[0]          <= cfg_pwdata[47:0];
        REG_ROT_ROW1:        rot_r[1]          <= cfg_pwdata[47:0];
        REG_ROT_ROW2:        rot_r[2]          <= cfg_pwdata[47:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DEPTH_SCALE:     cfg_prdata = CFG_DW'(depth_scale_r);
      REG_MIN_DEPTH:       cfg_prdata = CFG_DW'(min_depth_r);
      REG_MAX_DEPTH:       cfg_prdata = CFG_DW'(max_depth_r);
      REG_PRINCIPAL_POINT: cfg_prdata = CFG_DW'(principal_point_r);
      REG_INVERSE_FOCAL:   cfg_prdata = CFG_DW'(inverse_focal_r);
      REG_ROT_ROW0:        cfg_prdata = CFG_DW'(rot_r[0]);
      REG_ROT_ROW1:        cfg_prdata = CFG_DW'(rot_r[1]);
      REG_ROT_ROW2:        cfg_prdata = CFG_DW'(rot_r[2]);
    endcase
  end

  logic [PP_W-1:0] cx, cy;
  logic [IF_W-1:0] ifx, ify;
  logic signed [R_W-1:0] rot_m [3][3];

  assign cx  = principal_point_r[31:16];
  assign cy  = principal_point_r[15:0];
  assign ifx = inverse_focal_r[47:24];
  assign ify = inverse_focal_r[23:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot_m[i][j] = $signed(rot_r[i][R_W*(3-j)-1 -: R_W]);
      end
    end
  end

  // Stage handshake: a stage loads when it is empty or its item moves on.
  logic [NST:1] v_r;
  logic [NST:1] stage_en;

  always_comb begin
    stage_en[NST] = !v_r[NST] || out_pt.ready;
    for (int k = NST - 1; k >= 1; k--) begin
      stage_en[k] = !v_r[k] || stage_en[k+1];
    end
  end

  assign in_pix.ready = stage_en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (stage_en[1]) begin
        v_r[1] <= in_pix.valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (stage_en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: depth product and pixel offsets.
  logic [DPROD_W-1:0]    s1_dprod_r, s1_dprod_nxt;
  logic signed [DU_W-1:0] s1_du_r, s1_du_nxt, s1_dv_r, s1_dv_nxt;
  logic                  s1_bad_r;
  logic [UQ_W-1:0]       uq, vq;

  assign uq           = {in_pix.pixel_column, FRAC_SH'(0)};
  assign vq           = {in_pix.pixel_row, FRAC_SH'(0)};
  assign s1_dprod_nxt = DPROD_W'(in_pix.depth_sample) * DPROD_W'(depth_scale_r);
  assign s1_du_nxt    = DU_W'(uq) - DU_W'(cx);
  assign s1_dv_nxt    = DU_W'(vq) - DU_W'(cy);

  // Stage 2: scaled depth and range test.
  logic [Z_W-1:0]        s2_z_r, s2_z_nxt;
  logic                  s2_rej_r, s2_rej_nxt;
  logic signed [DU_W-1:0] s2_du_r, s2_dv_r;
  logic [DPROD_W-1:0]    zsum;

  assign zsum       = s1_dprod_r + (DPROD_W'(1) << (Z_SH - 1));
  assign s2_z_nxt   = zsum[DPROD_W-1:Z_SH];
  assign s2_rej_nxt = s1_bad_r || (s2_z_nxt < Z_W'(min_depth_r)) ||
                      (s2_z_nxt > Z_W'(max_depth_r));

  // Stage 3: offset times depth.
  logic signed [PXZ_W-1:0] s3_px_r, s3_px_nxt, s3_py_r, s3_py_nxt;
  logic [Z_W-1:0]          s3_z_r;
  logic                    s3_rej_r;

  assign s3_px_nxt = s2_du_r * $signed({1'b0, s2_z_r});
  assign s3_py_nxt = s2_dv_r * $signed({1'b0, s2_z_r});

  // Stage 4: partial products with the inverse focal lengths.
  logic signed [XH_W-1:0] s4_xh_r, s4_xh_nxt, s4_yh_r, s4_yh_nxt;
  logic [XL_W-1:0]        s4_xl_r, s4_xl_nxt, s4_yl_r, s4_yl_nxt;
  logic [Z_W-1:0]         s4_z_r;
  logic                   s4_rej_r;

  assign s4_xh_nxt = $signed(s3_px_r[PXZ_W-1:LO_W]) * $signed({1'b0, ifx});
  assign s4_yh_nxt = $signed(s3_py_r[PXZ_W-1:LO_W]) * $signed({1'b0, ify});
  assign s4_xl_nxt = XL_W'(s3_px_r[LO_W-1:0]) * XL_W'(ifx);
  assign s4_yl_nxt = XL_W'(s3_py_r[LO_W-1:0]) * XL_W'(ify);

  // Stage 5: camera-frame point.
  logic signed [PC_W-1:0]  s5_pc_r [3];
  logic signed [PC_W-1:0]  s5_pc_nxt [3];
  logic                    s5_rej_r;
  logic signed [PXF_W-1:0] comb_x, comb_y;
  logic signed [PXR_W-1:0] rs_x, rs_y;

  always_comb begin
    comb_x       = (PXF_W'(s4_xh_r) <<< LO_W) + PXF_W'(s4_xl_r);
    comb_y       = (PXF_W'(s4_yh_r) <<< LO_W) + PXF_W'(s4_yl_r);
    rs_x         = PXR_W'(comb_x) + (PXR_W'(1) <<< (PC_SH - 1));
    rs_y         = PXR_W'(comb_y) + (PXR_W'(1) <<< (PC_SH - 1));
    s5_pc_nxt[0] = PC_W'(rs_x >>> PC_SH);
    s5_pc_nxt[1] = PC_W'(rs_y >>> PC_SH);
    s5_pc_nxt[2] = PC_W'({s4_z_r, ZC_SH'(0)});
  end

  // Stage 6: rotation partial products.
  logic signed [PH_W-1:0] s6_ph_r [3][3];
  logic signed [PH_W-1:0] s6_ph_nxt [3][3];
  logic signed [PL_W-1:0] s6_pl_r [3][3];
  logic signed [PL_W-1:0] s6_pl_nxt [3][3];
  logic                   s6_rej_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s6_ph_nxt[i][j] = rot_m[i][j] * $signed(s5_pc_r[j][PC_W-1:PCLO_W]);
        s6_pl_nxt[i][j] = rot_m[i][j] * $signed({1'b0, s5_pc_r[j][PCLO_W-1:0]});
      end
    end
  end

  // Stage 7: full rotation products.
  logic signed [PR_W-1:0] s7_prod_r [3][3];
  logic signed [PR_W-1:0] s7_prod_nxt [3][3];
  logic                   s7_rej_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s7_prod_nxt[i][j] = (PR_W'(s6_ph_r[i][j]) <<< PCLO_W) + PR_W'(s6_pl_r[i][j]);
      end
    end
  end

  // Stage 8: row sums with translation.
  logic signed [ACC_W-1:0] s8_acc_r [3];
  logic signed [ACC_W-1:0] s8_acc_nxt [3];
  logic                    s8_rej_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s8_acc_nxt[i] = ACC_W'(s7_prod_r[i][0]) + ACC_W'(s7_prod_r[i][1]) +
                      ACC_W'(s7_prod_r[i][2]) + (ACC_W'(TRANS_Q24[i]) <<< TRANS_SH);
    end
  end

  // Stage 9: rounding, saturation and the output register.
  logic signed [POINT_W-1:0] pt_r [3];
  logic signed [POINT_W-1:0] pt_nxt [3];
  logic                      pval_r;
  logic signed [ACC_W:0]     ar [3];
  logic signed [RQ_W-1:0]    rq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ar[i] = (ACC_W + 1)'(s8_acc_r[i]) + ((ACC_W + 1)'(1) <<< (ACC_SH - 1));
      rq[i] = RQ_W'(ar[i] >>> ACC_SH);
      if (s8_rej_r) begin
        pt_nxt[i] = '0;
      end else if (rq[i] > SAT_HI) begin
        pt_nxt[i] = POINT_W'(SAT_HI);
      end else if (rq[i] < SAT_LO) begin
        pt_nxt[i] = POINT_W'(SAT_LO);
      end else begin
        pt_nxt[i] = rq[i][POINT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s1_dprod_r <= s1_dprod_nxt;
      s1_du_r    <= s1_du_nxt;
      s1_dv_r    <= s1_dv_nxt;
      s1_bad_r   <= in_pix.sample_bad;
    end
    if (stage_en[2]) begin
      s2_z_r   <= s2_z_nxt;
      s2_rej_r <= s2_rej_nxt;
      s2_du_r  <= s1_du_r;
      s2_dv_r  <= s1_dv_r;
    end
    if (stage_en[3]) begin
      s3_px_r  <= s3_px_nxt;
      s3_py_r  <= s3_py_nxt;
      s3_z_r   <= s2_z_r;
      s3_rej_r <= s2_rej_r;
    end
    if (stage_en[4]) begin
      s4_xh_r  <= s4_xh_nxt;
      s4_yh_r  <= s4_yh_nxt;
      s4_xl_r  <= s4_xl_nxt;
      s4_yl_r  <= s4_yl_nxt;
      s4_z_r   <= s3_z_r;
      s4_rej_r <= s3_rej_r;
    end
    if (stage_en[5]) begin
      s5_pc_r  <= s5_pc_nxt;
      s5_rej_r <= s4_rej_r;
    end
    if (stage_en[6]) begin
      s6_ph_r  <= s6_ph_nxt;
      s6_pl_r  <= s6_pl_nxt;
      s6_rej_r <= s5_rej_r;
    end
    if (stage_en[7]) begin
      s7_prod_r <= s7_prod_nxt;
      s7_rej_r  <= s6_rej_r;
    end
    if (stage_en[8]) begin
      s8_acc_r <= s8_acc_nxt;
      s8_rej_r <= s7_rej_r;
    end
    if (stage_en[9]) begin
      pt_r   <= pt_nxt;
      pval_r <= !s8_rej_r;
    end
  end

  assign out_pt.valid       = v_r[NST];
  assign out_pt.point_x     = pt_r[0];
  assign out_pt.point_y     = pt_r[1];
  assign out_pt.point_z     = pt_r[2];
  assign out_pt.point_valid = pval_r;

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_pt.valid && !out_pt.point_valid |->
      out_pt.point_x == '0 && out_pt.point_y == '0 && out_pt.point_z == '0)
    else $error("rejected pixel left a nonzero coordinate");

  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && !stage_en[1] |=> v_r[1] && $stable(s1_du_r) && $stable(s1_dprod_r))
    else $error("stalled first stage lost its item");

  a_reject_flag: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && stage_en[NST] && s8_rej_r |=> out_pt.valid && !out_pt.point_valid)
    else $error("rejected pixel reached the output as valid");

  a_bad_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && stage_en[2] && s1_bad_r |=> v_r[2] && s2_rej_r)
    else $error("non-finite sample was not rejected");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import dpt_pkg::*;

  typedef struct packed {
    logic [15:0] depth_sample;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic        sample_bad;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               point_valid;
  } point_t;

  typedef struct packed {
    logic [1:0] phase;
    pixel_t     pix;
    logic       exact;
    point_t     want;
  } pixel_case_t;

  localparam int NUM_DIRECTED  = 19;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 222;

  localparam longint OFFSET_Q24 [3] = '{-64'sd1205257, -64'sd587201, -64'sd1423069};

  localparam point_t REJECTED  = '{16'sd0, 16'sd0, 16'sd0, 1'b0};
  localparam point_t AT_OFFSET = '{-16'sd18, -16'sd9, -16'sd22, 1'b1};

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  dpt_pixel_if pix ();
  dpt_point_if pt ();

  depth_pixel_to_point_transform dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pix      (pix),
    .out_pt      (pt),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  logic [63:0] reg_file [8];
  point_t pending_points [$];
  int mismatch_count = 0;
  int hold_left = 0;
  bit gaps_on = 1'b1;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [63:0] reg_mask(input cfg_idx_t idx);
    case (idx)
      REG_DEPTH_SCALE, REG_MIN_DEPTH, REG_MAX_DEPTH: return 64'hFFFF;
      REG_PRINCIPAL_POINT: return 64'hFFFF_FFFF;
      default: return 64'hFFFF_FFFF_FFFF;
    endcase
  endfunction

  function automatic longint round_half_up(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic point_t project_pixel(input pixel_t p);
    point_t res;
    longint z;
    longint du;
    longint dv;
    longint acc;
    longint q;
    longint pc [3];
    longint outv [3];
    logic [63:0] row;
    res = REJECTED;
    z = (longint'(p.depth_sample) * longint'(reg_file[REG_DEPTH_SCALE][15:0]) + 8192) >>> 14;
    if (p.sample_bad || z < longint'(reg_file[REG_MIN_DEPTH][15:0]) ||
        z > longint'(reg_file[REG_MAX_DEPTH][15:0])) begin
      return res;
    end
    du = longint'({p.pixel_column, 4'b0000}) - longint'(reg_file[REG_PRINCIPAL_POINT][31:16]);
    dv = longint'({p.pixel_row, 4'b0000}) - longint'(reg_file[REG_PRINCIPAL_POINT][15:0]);
    pc[0] = round_half_up(du * z * longint'(reg_file[REG_INVERSE_FOCAL][47:24]), 20);
    pc[1] = round_half_up(dv * z * longint'(reg_file[REG_INVERSE_FOCAL][23:0]), 20);
    pc[2] = z * 256;
    for (int i = 0; i < 3; i++) begin
      row = reg_file[int'(REG_ROT_ROW0) + i];
      acc = OFFSET_Q24[i] * 64;
      for (int j = 0; j < 3; j++) begin
        acc += longint'($signed(row[47 - 16 * j -: 16])) * pc[j];
      end
      q = round_half_up(acc, 22);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      outv[i] = q;
    end
    res.point_x = 16'(outv[0]);
    res.point_y = 16'(outv[1]);
    res.point_z = 16'(outv[2]);
    res.point_valid = 1'b1;
    return res;
  endfunction

  function automatic logic [15:0] pick_depth();
    longint s;
    longint lo;
    longint hi;
    longint zt;
    longint d;
    s = longint'(reg_file[REG_DEPTH_SCALE][15:0]);
    lo = longint'(reg_file[REG_MIN_DEPTH][15:0]);
    hi = longint'(reg_file[REG_MAX_DEPTH][15:0]);
    if (s == 0 || hi < lo || $urandom_range(0, 4) == 0) return 16'($urandom);
    case ($urandom_range(0, 5))
      0: zt = lo;
      1: zt = hi;
      2: zt = lo - 1;
      3: zt = hi + 1;
      default: zt = lo + longint'($urandom) % (hi - lo + 1);
    endcase
    if (zt < 0) zt = 0;
    d = (zt * 16384 + s / 2) / s;
    if (d > 65535) d = 65535;
    return 16'(d);
  endfunction

  function automatic logic [15:0] pick_rotation();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic pixel_case_t dcase(input logic [1:0] phase, input logic [15:0] d,
                                        input logic [11:0] u, input logic [11:0] v,
                                        input logic bad, input logic exact,
                                        input point_t want);
    pixel_case_t c;
    c.phase = phase;
    c.pix = '{d, u, v, bad};
    c.exact = exact;
    c.want = want;
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic apb_cycle(input cfg_idx_t idx, input bit wr, input logic [63:0] data);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = wr;
    cfg_paddr = CFG_AW'(int'(idx) << IDX_LSB);
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (!wr && cfg_prdata !== reg_file[idx]) begin
      report_mismatch($sformatf("register %s read %h, expected %h",
                                idx.name(), cfg_prdata, reg_file[idx]));
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // Bits above the register width carry random junk that the block must drop.
  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
    logic [63:0] sent;
    sent = ({$urandom, $urandom} & ~reg_mask(idx)) | (value & reg_mask(idx));
    reg_file[idx] = value & reg_mask(idx);
    apb_cycle(idx, 1'b1, sent);
    apb_cycle(idx, 1'b0, 64'd0);
  endtask

  task automatic wait_points_drained();
    pix.valid = 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  task automatic send_pixel(input pixel_t p, input logic exact, input point_t want);
    while (gaps_on && $urandom_range(0, 99) < 13) begin
      pix.valid = 1'b0;
      @(negedge clk);
    end
    pix.valid = 1'b1;
    pix.depth_sample = p.depth_sample;
    pix.pixel_column = p.pixel_column;
    pix.pixel_row = p.pixel_row;
    pix.sample_bad = p.sample_bad;
    do @(posedge clk); while (!pix.ready);
    pending_points.push_back(exact ? want : project_pixel(p));
    @(negedge clk);
  endtask

  task automatic apply_directed_setting(input logic [1:0] phase);
    if (phase == 2'd1) begin
      write_reg(REG_DEPTH_SCALE, 64'hFFFF);
      write_reg(REG_MIN_DEPTH, 64'd0);
      write_reg(REG_MAX_DEPTH, 64'hFFFF);
      write_reg(REG_PRINCIPAL_POINT, 64'hFFFF_0000);
      write_reg(REG_INVERSE_FOCAL, 64'hFFFF_FFFF_FFFF);
      write_reg(REG_ROT_ROW0, {16'd16384, 16'd0, 16'd0});
      write_reg(REG_ROT_ROW1, {16'd0, 16'd16384, 16'd0});
      write_reg(REG_ROT_ROW2, {16'd0, 16'd0, 16'd16384});
    end else begin
      write_reg(REG_DEPTH_SCALE, 64'd16384);
      write_reg(REG_MIN_DEPTH, 64'd1000);
      write_reg(REG_MAX_DEPTH, 64'd999);
    end
  endtask

  task automatic apply_random_setting(input int k);
    logic [15:0] lo;
    if (k == 0) begin
      write_reg(REG_DEPTH_SCALE, 64'hFFFF);
      write_reg(REG_MIN_DEPTH, 64'd0);
      write_reg(REG_MAX_DEPTH, 64'hFFFF);
      write_reg(REG_PRINCIPAL_POINT, 64'hFFFF_FFFF);
      write_reg(REG_INVERSE_FOCAL, 64'hFFFF_FFFF_FFFF);
      write_reg(REG_ROT_ROW0, {16'h7FFF, 16'h8000, 16'h7FFF});
      write_reg(REG_ROT_ROW1, {16'h8000, 16'h7FFF, 16'h8000});
      write_reg(REG_ROT_ROW2, {16'h7FFF, 16'h7FFF, 16'h8000});
    end else if (k == 1) begin
      write_reg(REG_DEPTH_SCALE, 64'd0);
      write_reg(REG_MIN_DEPTH, 64'd0);
      write_reg(REG_MAX_DEPTH, 64'd0);
      write_reg(REG_PRINCIPAL_POINT, 64'd0);
      write_reg(REG_INVERSE_FOCAL, 64'd0);
      write_reg(REG_ROT_ROW0, {16'h8000, 16'h8000, 16'h8000});
      write_reg(REG_ROT_ROW1, 64'd0);
      write_reg(REG_ROT_ROW2, {16'h7FFF, 16'h0000, 16'h8000});
    end else begin
      lo = 16'($urandom_range(0, 400));
      write_reg(REG_DEPTH_SCALE, 64'($urandom_range(8000, 30000)));
      write_reg(REG_MIN_DEPTH, 64'(lo));
      write_reg(REG_MAX_DEPTH, 64'($urandom_range(int'(lo) + 100, 65535)));
      write_reg(REG_PRINCIPAL_POINT, 64'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_INVERSE_FOCAL, {$urandom, $urandom});
      end else begin
        write_reg(REG_INVERSE_FOCAL, {24'($urandom_range(5000, 200000)),
                                      24'($urandom_range(5000, 200000))});
      end
      write_reg(REG_ROT_ROW0, {pick_rotation(), pick_rotation(), pick_rotation()});
      write_reg(REG_ROT_ROW1, {pick_rotation(), pick_rotation(), pick_rotation()});
      write_reg(REG_ROT_ROW2, {pick_rotation(), pick_rotation(), pick_rotation()});
    end
  endtask

  initial begin
    pt.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pt.ready = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        pt.ready = !(gaps_on && $urandom_range(0, 99) < 13);
      end
    end
  end

  always @(posedge clk) begin
    point_t seen;
    point_t want;
    if (rst_n && pt.valid && pt.ready) begin
      seen = '{pt.point_x, pt.point_y, pt.point_z, pt.point_valid};
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("point transfer with nothing pending: %p", seen));
      end else begin
        want = pending_points.pop_front();
        if (seen.point_x !== want.point_x || seen.point_y !== want.point_y ||
            seen.point_z !== want.point_z || seen.point_valid !== want.point_valid) begin
          report_mismatch($sformatf("point x/y/z/valid got %0d %0d %0d %b, expected %0d %0d %0d %b",
                                    seen.point_x, seen.point_y, seen.point_z, seen.point_valid,
                                    want.point_x, want.point_y, want.point_z, want.point_valid));
        end
      end
    end
  end

  initial begin
    pixel_case_t directed_cases [NUM_DIRECTED];
    pixel_t p;
    logic [1:0] cur_phase;
    int drain_wait;

    rst_n = 1'b0;
    pix.valid = 1'b0;
    pix.depth_sample = '0;
    pix.pixel_column = '0;
    pix.pixel_row = '0;
    pix.sample_bad = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;

    reg_file[REG_DEPTH_SCALE] = 64'd13107;
    reg_file[REG_MIN_DEPTH] = 64'd51;
    reg_file[REG_MAX_DEPTH] = 64'd2560;
    reg_file[REG_PRINCIPAL_POINT] = 64'd1005789613;
    reg_file[REG_INVERSE_FOCAL] = 64'd349536538963;
    reg_file[REG_ROT_ROW0] = 64'd0;
    reg_file[REG_ROT_ROW1] = 64'd0;
    reg_file[REG_ROT_ROW2] = 64'd0;

    // With the reset matrix all zero, every accepted pixel lands on the rounded offset.
    directed_cases = '{
      dcase(2'd0, 16'd0,     12'd100,  12'd100,  1'b0, 1'b1, REJECTED),
      dcase(2'd0, 16'hFFFF,  12'd100,  12'd100,  1'b0, 1'b1, REJECTED),
      dcase(2'd0, 16'd63,    12'd10,   12'd20,   1'b0, 1'b1, REJECTED),
      dcase(2'd0, 16'd64,    12'd10,   12'd20,   1'b0, 1'b1, AT_OFFSET),
      dcase(2'd0, 16'd3200,  12'd30,   12'd40,   1'b0, 1'b1, AT_OFFSET),
      dcase(2'd0, 16'd3201,  12'd30,   12'd40,   1'b0, 1'b1, REJECTED),
      dcase(2'd0, 16'd1000,  12'd50,   12'd60,   1'b1, 1'b1, REJECTED),
      dcase(2'd0, 16'd1000,  12'd0,    12'd0,    1'b0, 1'b1, AT_OFFSET),
      dcase(2'd0, 16'd1000,  12'hFFF,  12'hFFF,  1'b0, 1'b1, AT_OFFSET),
      dcase(2'd0, 16'd1000,  12'hFFF,  12'd0,    1'b0, 1'b1, AT_OFFSET),
      dcase(2'd1, 16'hFFFF,  12'd0,    12'hFFF,  1'b0, 1'b0, REJECTED),
      dcase(2'd1, 16'hFFFF,  12'hFFF,  12'd0,    1'b0, 1'b0, REJECTED),
      dcase(2'd1, 16'd1,     12'd0,    12'd0,    1'b0, 1'b0, REJECTED),
      dcase(2'd1, 16'd0,     12'h800,  12'h800,  1'b0, 1'b0, REJECTED),
      dcase(2'd1, 16'hFFFF,  12'hFFF,  12'hFFF,  1'b1, 1'b1, REJECTED),
      dcase(2'd2, 16'd999,   12'd5,    12'd5,    1'b0, 1'b1, REJECTED),
      dcase(2'd2, 16'd1000,  12'd5,    12'd5,    1'b0, 1'b1, REJECTED),
      dcase(2'd2, 16'hFFFF,  12'hFFF,  12'd0,    1'b0, 1'b1, REJECTED),
      dcase(2'd2, 16'd0,     12'd0,    12'hFFF,  1'b0, 1'b1, REJECTED)
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < 8; i++) apb_cycle(cfg_idx_t'(i), 1'b0, 64'd0);

    cur_phase = 2'd0;
    foreach (directed_cases[i]) begin
      if (directed_cases[i].phase != cur_phase) begin
        wait_points_drained();
        cur_phase = directed_cases[i].phase;
        apply_directed_setting(cur_phase);
      end
      send_pixel(directed_cases[i].pix, directed_cases[i].exact, directed_cases[i].want);
    end

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      wait_points_drained();
      apply_random_setting(k);
      gaps_on = (k != 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // A long output stall backs the pipeline up into the pixel input.
        if (k == 2 && n == 60) hold_left = 300;
        if (k == 3 && n == 100) wait_points_drained();
        p.depth_sample = pick_depth();
        p.pixel_column = 12'($urandom);
        p.pixel_row = 12'($urandom);
        p.sample_bad = ($urandom_range(0, 9) == 0);
        send_pixel(p, 1'b0, REJECTED);
      end
    end
    gaps_on = 1'b1;

    pix.valid = 1'b0;
    drain_wait = 0;
    while (pending_points.size() != 0 && drain_wait < 5000) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (12) @(posedge clk);
    if (pending_points.size() != 0) begin
      report_mismatch($sformatf("%0d points never arrived", pending_points.size()));
    end

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/dpt_pkg.sv
rtl/core/dpt_pixel_if.sv
rtl/core/dpt_point_if.sv
rtl/core/depth_pixel_to_point_transform.sv
tb/tb.sv
